// ===== rtl/fourier_series_analyse_synthesise_macros.svh =====
// Assertion helpers for the RTL, used by fss_controller.
`ifndef FOURIER_SERIES_ANALYSE_SYNTHESISE_MACROS_SVH
`define FOURIER_SERIES_ANALYSE_SYNTHESISE_MACROS_SVH

`ifndef SYNTHESIS
`define FSS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSS_ASSERT_SAME(label, clk, rst, ante, cons)
`define FSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/fss_pkg.sv =====
package fss_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int CFG_W    = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd20;
  localparam int ACC_W    = 48;
  localparam int COEF_W   = 18;
  localparam int TRIG_W   = 17;
  localparam int PROD_W   = COEF_W + TRIG_W;
  localparam int ROM_W    = 16;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_EVAL   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN1,
    S_DRAIN2,
    S_FINISH
  } fss_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } fss_cmd_t;

  typedef struct packed {
    logic n_last;
    logic is_eval;
    logic out_busy;
  } fss_sts_t;

  // sin((pi/2)*m/quarter) rounded to Q1.15, quarter = 2^(tb-2)
  function automatic logic [ROM_W-1:0] qsine(int tb, int m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    int k;
    x = (64'd3373259426 * 64'(m)) >> (tb - 1);
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    if (v < 64'sd0) v = 64'sd0;
    return v[ROM_W-1:0];
  endfunction

endpackage

// ===== rtl/fss_item_if.sv =====
interface fss_item_if;
  import fss_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  logic signed [SAMPLE_W-1:0] sample;
  logic last;
  logic [PHASE_W-1:0] phase;
  modport source (output valid, mode, sample, last, phase, input ready);
  modport sink (input valid, mode, sample, last, phase, output ready);
endinterface

// ===== rtl/fss_result_if.sv =====
interface fss_result_if;
  import fss_pkg::*;
  logic valid;
  logic ready;
  logic signed [VALUE_W-1:0] value;
  logic coeffs_valid;
  modport source (output valid, value, coeffs_valid, input ready);
  modport sink (input valid, value, coeffs_valid, output ready);
endinterface

// ===== rtl/fss_cfg_if.sv =====
interface fss_cfg_if;
  import fss_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/fss_datapath.sv =====
module fss_datapath
  import fss_pkg::*;
#(
  parameter int HARMONICS   = 20,
  parameter int NUM_SAMPLES = 256,
  parameter int TABLE_BITS  = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fss_cmd_t                   cmd,
  output fss_sts_t                   sts,
  input  logic                       mode,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  input  logic [PHASE_W-1:0]         phase,
  input  logic                       cfg_we,
  input  logic [CFG_W-1:0]           cfg_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic signed [VALUE_W-1:0]  res_value,
  output logic                       res_coeffs_valid
);

  localparam int DEPTH       = HARMONICS + 1;
  localparam int NW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LOG_N       = $clog2(NUM_SAMPLES);
  localparam int TAB_QUARTER = 1 << (TABLE_BITS - 2);
  localparam int MW          = TABLE_BITS - 1;
  localparam int SH          = LOG_N + 14;
  localparam int STEP_SH     = 31 - LOG_N;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (LOG_N + 13);

  logic [ROM_W-1:0] qtab [TAB_QUARTER+1];
  for (genvar g = 0; g <= TAB_QUARTER; g++) begin : g_rom
    localparam logic [ROM_W-1:0] V = qsine(TABLE_BITS, g);
    assign qtab[g] = V;
  end

  logic [ACC_W-1:0] cos_mem [DEPTH];
  logic [ACC_W-1:0] sin_mem [DEPTH];

  logic                       item_mode;
  logic signed [SAMPLE_W-1:0] item_sample;
  logic                       item_last;
  logic [PHASE_W-1:0]         item_phase;
  logic [CFG_W-1:0]           harm;
  logic [LOG_N-1:0]           sample_index;
  logic                       finalised;
  logic                       first;
  logic                       fin;

  logic [NW-1:0]  n_a;
  logic [31:0]    angle;
  logic [31:0]    step;
  logic [TABLE_BITS:0]   t_top;
  logic [TABLE_BITS-1:0] sidx;
  logic [TABLE_BITS-1:0] cidx;
  logic [MW-1:0]  sm;
  logic [MW-1:0]  cm;

  logic           vld_b, on_b, zero_b, sneg_b, cneg_b;
  logic [NW-1:0]  n_b;
  logic [ROM_W-1:0] srom, crom;
  logic [ACC_W-1:0] cos_rd, sin_rd;
  logic signed [TRIG_W-1:0] ctrig, strig;
  logic signed [COEF_W-1:0] ca, sa;

  logic           vld_c;
  logic [NW-1:0]  n_c;
  logic signed [PROD_W-1:0] pc, ps;
  logic signed [ACC_W-1:0]  cbase, sbase;
  logic signed [ACC_W-1:0]  csum, ssum, cwr, swr;
  logic signed [ACC_W-1:0]  eacc, eround;
  logic signed [VALUE_W-1:0] sat;

  function automatic logic [MW-1:0] mirror(logic [TABLE_BITS-1:0] idx);
    logic [MW-1:0] q;
    q = {1'b0, idx[TABLE_BITS-3:0]};
    return idx[TABLE_BITS-2] ? MW'(TAB_QUARTER) - q : q;
  endfunction

  assign first = (sample_index == '0);
  assign fin   = (sample_index == LOG_N'(NUM_SAMPLES - 1));

  assign sts.n_last   = (n_a == NW'(HARMONICS));
  assign sts.is_eval  = (item_mode == MODE_EVAL);
  assign sts.out_busy = res_valid && !res_ready;

  always_comb begin
    if (item_mode == MODE_EVAL) begin
      step = {item_phase, 16'b0};
    end else begin
      step = 32'({sample_index, 1'b1}) << STEP_SH;
    end
  end

  assign t_top = angle[31 -: TABLE_BITS+1];
  assign sidx  = TABLE_BITS'(({1'b0, t_top} + (TABLE_BITS+2)'(1)) >> 1);
  assign cidx  = sidx + TABLE_BITS'(TAB_QUARTER);
  assign sm    = mirror(sidx);
  assign cm    = mirror(cidx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode   <= mode;
      item_sample <= sample;
      item_last   <= last;
      item_phase  <= phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      harm <= CFG_RESET;
    end else if (cfg_we) begin
      harm <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_a   <= '0;
      angle <= '0;
    end else if (cmd.load) begin
      n_a   <= '0;
      angle <= '0;
    end else if (cmd.issue) begin
      n_a   <= n_a + 1'b1;
      angle <= angle + step;
    end
  end

  // stage B: table and accumulator reads
  always_ff @(posedge clk) begin
    srom   <= qtab[sm];
    crom   <= qtab[cm];
    sneg_b <= sidx[TABLE_BITS-1];
    cneg_b <= cidx[TABLE_BITS-1];
    cos_rd <= cos_mem[n_a];
    sin_rd <= sin_mem[n_a];
    n_b    <= n_a;
    zero_b <= (n_a == '0);
    on_b   <= (32'(n_a) <= 32'(harm));
  end

  always_comb begin
    if (!on_b) begin
      ctrig = '0;
    end else if (zero_b) begin
      ctrig = (item_mode == MODE_EVAL) ? 17'sd16384 : 17'sd32768;
    end else if (cneg_b) begin
      ctrig = -$signed({1'b0, crom});
    end else begin
      ctrig = $signed({1'b0, crom});
    end
    if (!on_b || zero_b) begin
      strig = '0;
    end else if (sneg_b) begin
      strig = -$signed({1'b0, srom});
    end else begin
      strig = $signed({1'b0, srom});
    end
    if (item_mode == MODE_EVAL) begin
      ca = $signed(cos_rd[COEF_W-1:0]);
      sa = $signed(sin_rd[COEF_W-1:0]);
    end else begin
      ca = COEF_W'(item_sample);
      sa = COEF_W'(item_sample);
    end
  end

  // stage C: products
  always_ff @(posedge clk) begin
    pc    <= ca * ctrig;
    ps    <= sa * strig;
    cbase <= $signed(cos_rd);
    sbase <= $signed(sin_rd);
    n_c   <= n_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else begin
      vld_b <= cmd.issue;
      vld_c <= vld_b;
    end
  end

  always_comb begin
    csum = (first ? '0 : cbase) + ACC_W'(pc);
    ssum = (first ? '0 : sbase) + ACC_W'(ps);
    cwr  = fin ? ((csum + RND) >>> SH) : csum;
    swr  = fin ? ((ssum + RND) >>> SH) : ssum;
  end

  always_ff @(posedge clk) begin
    if (vld_c && item_mode == MODE_SAMPLE) begin
      cos_mem[n_c] <= cwr;
      sin_mem[n_c] <= swr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      eacc <= '0;
    end else if (vld_c && item_mode == MODE_EVAL) begin
      eacc <= eacc + ACC_W'(pc) + ACC_W'(ps);
    end
  end

  always_comb begin
    eround = (eacc + ACC_W'(16384)) >>> 15;
    if (eround > ACC_W'(64'sd2147483647)) begin
      sat = 32'sh7fffffff;
    end else if (eround < -ACC_W'(64'sd2147483648)) begin
      sat = 32'sh80000000;
    end else begin
      sat = eround[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      finalised    <= 1'b0;
    end else if (cmd.finish && item_mode == MODE_SAMPLE) begin
      if (fin) begin
        sample_index <= '0;
        finalised    <= 1'b1;
      end else begin
        sample_index <= item_last ? '0 : sample_index + 1'b1;
        if (first) finalised <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish && item_mode == MODE_EVAL) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && item_mode == MODE_EVAL) begin
      res_value        <= finalised ? sat : '0;
      res_coeffs_valid <= finalised;
    end
  end

endmodule

// ===== rtl/fss_controller.sv =====
`include "fourier_series_analyse_synthesise_macros.svh"

module fss_controller
  import fss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  fss_sts_t sts,
  output fss_cmd_t cmd
);

  fss_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_RUN;
      end
      S_RUN: begin
        if (sts.n_last) state_next = S_DRAIN1;
      end
      S_DRAIN1: state_next = S_DRAIN2;
      S_DRAIN2: state_next = S_FINISH;
      S_FINISH: begin
        if (!(sts.is_eval && sts.out_busy)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        item_ready = !rst;
        cmd.load   = item_valid && !rst;
      end
      S_RUN: cmd.issue = 1'b1;
      S_FINISH: cmd.finish = !(sts.is_eval && sts.out_busy);
      default: cmd = '0;
    endcase
  end

  `FSS_ASSERT_NEXT(a_load_runs, clk, rst, cmd.load, state == S_RUN)
  `FSS_ASSERT_NEXT(a_finish_idles, clk, rst, cmd.finish, state == S_IDLE)
  `FSS_ASSERT_NEXT(a_sweep_drains, clk, rst, state == S_RUN && sts.n_last, state == S_DRAIN1)
  `FSS_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.finish && sts.is_eval, !sts.out_busy)

endmodule

// ===== rtl/fourier_series_analyse_synthesise.sv =====
// Fourier series analyser / synthesiser.
// Channels: item (mode, sample, last, phase), result (value, coeffs_valid),
// cfg (harmonics_in_use write). All use valid/ready; a transfer happens on a
// rising clk edge with both high. cfg is ready whenever rst is low.
// A sample item (mode 0) accumulates sample*cos and sample*sin for every
// harmonic up to harmonics_in_use; the final sample of a period scales the
// sums into coefficients. It gives no result. An evaluate item (mode 1)
// gives one result. Each item sweeps harmonics 0..HARMONICS, one cos/sin
// multiply-accumulate pair per cycle through a three-stage
// read/multiply/write pipeline; the controller steps through run, drain1,
// drain2 and finish, and takes the next item only once back in idle. An
// evaluate result sits in an output register after the finish step; the
// next item is taken while it waits. If the receiver stalls, a further
// evaluate holds at its finish step until the register frees.
// Reset (rst, synchronous) empties the pipeline, clears sample count and the
// coefficient flag, and sets harmonics_in_use to 20. NUM_SAMPLES is a power
// of two.
module fourier_series_analyse_synthesise
  import fss_pkg::*;
#(
  parameter int HARMONICS   = 20,
  parameter int NUM_SAMPLES = 256,
  parameter int TABLE_BITS  = 10
) (
  input logic         clk,
  input logic         rst,
  fss_item_if.sink    item,
  fss_result_if.source result,
  fss_cfg_if.sink     cfg
);

  fss_cmd_t cmd;
  fss_sts_t sts;

  assign cfg.ready = !rst;

  fss_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .item_ready(item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fss_datapath #(
    .HARMONICS  (HARMONICS),
    .NUM_SAMPLES(NUM_SAMPLES),
    .TABLE_BITS (TABLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .mode            (item.mode),
    .sample          (item.sample),
    .last            (item.last),
    .phase           (item.phase),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.data),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_value       (result.value),
    .res_coeffs_valid(result.coeffs_valid)
  );

endmodule
